// File: rtl/base64_stream_encoder_core_macros.svh
// assertion macros used by the encoder checker
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define B64_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication that also holds across reset
`define B64_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/b64enc_pkg.sv
// shared types, constants and the sextet to character mapping
`default_nettype none

package b64enc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_CHARS   = 4;

  localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
  localparam logic [6:0] CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [6:0] CHAR_DIGIT = 7'h30;  // '0'
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH = 7'h2F;  // '/'

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } grp_pos_t;

  // characters produced by one byte, handed from front to back
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [1:0]                last_idx;
    logic                      msg_last;
  } job_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = CHAR_SLASH;
    if (v < 6'd26) begin
      c = CHAR_UPPER + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CHAR_DIGIT + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64enc_front.sv
// byte intake: tracks the group position and builds the characters for each byte
`default_nettype none

module b64enc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              q_full,
  output logic                   push,
  output b64enc_pkg::job_t       job
);

  b64enc_pkg::grp_pos_t pos, pos_next;
  logic [3:0]           carry, carry_next;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // next position and leftover bits
  always_comb begin
    pos_next   = pos;
    carry_next = carry;
    if (push) begin
      case (pos)
        b64enc_pkg::POS_SECOND: begin
          if (last_byte) begin
            pos_next   = b64enc_pkg::POS_FIRST;
            carry_next = '0;
          end else begin
            pos_next   = b64enc_pkg::POS_THIRD;
            carry_next = data_byte[3:0];
          end
        end
        b64enc_pkg::POS_THIRD: begin
          pos_next   = b64enc_pkg::POS_FIRST;
          carry_next = '0;
        end
        default: begin
          if (last_byte) begin
            pos_next   = b64enc_pkg::POS_FIRST;
            carry_next = '0;
          end else begin
            pos_next   = b64enc_pkg::POS_SECOND;
            carry_next = {2'b00, data_byte[1:0]};
          end
        end
      endcase
    end
  end

  // characters for the byte on the input
  always_comb begin
    job          = '0;
    job.msg_last = last_byte;
    case (pos)
      b64enc_pkg::POS_SECOND: begin
        job.chars[0] = b64enc_pkg::sextet_char({carry[1:0], data_byte[7:4]});
        if (last_byte) begin
          job.chars[1] = b64enc_pkg::sextet_char({data_byte[3:0], 2'b00});
          job.chars[2] = b64enc_pkg::PAD_CHAR;
          job.last_idx = 2'd2;
        end else begin
          job.last_idx = 2'd0;
        end
      end
      b64enc_pkg::POS_THIRD: begin
        job.chars[0] = b64enc_pkg::sextet_char({carry, data_byte[7:6]});
        job.chars[1] = b64enc_pkg::sextet_char(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.chars[0] = b64enc_pkg::sextet_char(data_byte[7:2]);
        if (last_byte) begin
          job.chars[1] = b64enc_pkg::sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2] = b64enc_pkg::PAD_CHAR;
          job.chars[3] = b64enc_pkg::PAD_CHAR;
          job.last_idx = 2'd3;
        end else begin
          job.last_idx = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= b64enc_pkg::POS_FIRST;
      carry <= '0;
    end else begin
      pos   <= pos_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_queue.sv
// short register queue of character groups between intake and output
`default_nettype none

module b64enc_queue #(
  parameter int Depth = b64enc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64enc_pkg::job_t wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output b64enc_pkg::job_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64enc_pkg::job_t  entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count, count_next;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_back.sv
// output side: walks each queued group one character per cycle into the output register while out_ready allows
`default_nettype none

module b64enc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire b64enc_pkg::job_t  head,
  output logic                   pop,
  output logic [6:0]             out_char,
  output logic                   last_char,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  logic [1:0] idx;
  logic       emit;
  logic       at_end;

  assign emit   = head_valid && (!out_valid || out_ready);
  assign at_end = (idx == head.last_idx);
  assign pop    = emit && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char  <= head.chars[idx];
      last_char <= head.msg_last && at_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/base64_stream_encoder_core.sv
// base64 encoder: one byte in, one to four characters out, one character per cycle unless the output stalls
// path: a byte is written into the group queue, then its first character into the output register
// throughput: one character per cycle from the output register while out_ready allows, 4 characters
// per 3 bytes; the intake stalls only when the group queue is full
// reset: synchronous rst clears group position, leftover bits, queue and output valid
`default_nettype none

module base64_stream_encoder_core #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [6:0]      out_char,
  output logic            last_char,
  output logic            out_valid,
  input  wire logic       out_ready
);

  b64enc_pkg::job_t new_job;
  b64enc_pkg::job_t head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             head_valid;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .push      (push),
    .job       (new_job)
  );

  b64enc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (new_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_char   (out_char),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

// File: rtl/b64enc_checker.sv
// port-level checks for the encoder, bound to the top level
`default_nettype none

`include "base64_stream_encoder_core_macros.svh"

module b64enc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [6:0] out_char,
  input wire logic       last_char,
  input wire logic       out_valid,
  input wire logic       out_ready
);

  logic char_legal;
  logic in_seen;

  assign in_seen = in_valid && in_ready;

  assign char_legal =
      (out_char >= b64enc_pkg::CHAR_UPPER && out_char <= 7'h5A) ||
      (out_char >= b64enc_pkg::CHAR_LOWER && out_char <= 7'h7A) ||
      (out_char >= b64enc_pkg::CHAR_DIGIT && out_char <= 7'h39) ||
      (out_char == b64enc_pkg::CHAR_PLUS) ||
      (out_char == b64enc_pkg::CHAR_SLASH) ||
      (out_char == b64enc_pkg::PAD_CHAR);

  // a stalled character stays put until taken
  `B64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_char) && $stable(last_char), "stalled output changed")

  // only alphabet characters and padding leave the block
  `B64_ASSERT_IMPL(a_char_legal, out_valid, char_legal, "output outside base64 alphabet")

  // a byte transfer is followed by a character on the output once it has passed the queue and the output register
  `B64_ASSERT_NEXT(a_in_then_out, in_seen, ##1 out_valid, "no character after byte transfer")

  // reset leaves nothing on the output
  `B64_ASSERT_ALWAYS(a_reset_clear, $past(rst), !out_valid, "output valid after reset")

endmodule

bind base64_stream_encoder_core b64enc_checker u_checker (.*);

`default_nettype wire
